/* design/lrhg_pkg.sv */
// ============================================================================
// lrhg_pkg : shared types and constants for the LED ring hue gradient core
// Widths, register indexes, the front-to-back command word, divider
// request/response groups and the front sequencer states.
// ============================================================================
package lrhg_pkg;

    // ring limits
    localparam int MAX_PIXELS = 64;
    localparam int IDX_W      = $clog2(MAX_PIXELS);   // pixel index width
    localparam int CNT_W      = IDX_W + 1;            // holds MAX_PIXELS itself

    // field widths
    localparam int HUE_W      = 9;
    localparam int PCT_W      = 7;
    localparam int CH_W       = 8;
    localparam int STEP_W     = HUE_W + 1;            // signed hue step
    localparam int CFG_DATA_W = 8;

    // hue constants
    localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;
    localparam logic [HUE_W-1:0] HUE_SECTOR = 9'd60;
    localparam logic [CH_W-1:0]  CH_ON      = 8'd255;
    localparam logic [CH_W-1:0]  CH_OFF     = 8'd0;
    localparam int               PCT_FULL   = 100;

    // brightness: max_brightness * percent / 100 by reciprocal multiply
    // ceil(2^19 / 100) is exact for every product below 43699
    localparam int               PROD_W    = CH_W + PCT_W;
    localparam int               RECIP_W   = 13;
    localparam int               RECIP_SH  = 19;
    localparam int               BQ_W      = PROD_W + RECIP_W - RECIP_SH;
    localparam logic [RECIP_W-1:0] PCT_RECIP = 13'd5243;

    // color sectors
    localparam logic [2:0] SEC_RY = 3'd0;   // red to yellow
    localparam logic [2:0] SEC_YG = 3'd1;   // yellow to green
    localparam logic [2:0] SEC_GC = 3'd2;   // green to cyan
    localparam logic [2:0] SEC_CB = 3'd3;   // cyan to blue
    localparam logic [2:0] SEC_BM = 3'd4;   // blue to magenta
    localparam logic [2:0] SEC_MR = 3'd5;   // magenta to red

    // configuration register indexes
    localparam logic CFG_RING_SIZE  = 1'b0;
    localparam logic CFG_MAX_BRIGHT = 1'b1;

    localparam logic [CNT_W-1:0] RING_SIZE_RST  = 7'd24;
    localparam logic [CH_W-1:0]  MAX_BRIGHT_RST = 8'd255;

    // shared divider
    localparam int DIV_DVD_W = STEP_W;                // widest dividend: hue difference
    localparam int DIV_DSR_W = PCT_W;                 // widest divisor
    localparam int DIV_STEPS = DIV_DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // command queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
        logic [DIV_DSR_W-1:0] remainder;
    } t_div_rsp;

    // one prepared request, front to back
    typedef struct packed {
        logic [IDX_W-1:0]  first;
        logic [CNT_W-1:0]  ring;
        logic [CNT_W-1:0]  count;
        logic [HUE_W-1:0]  hue_start;
        logic [STEP_W-1:0] step;
        logic [CH_W-1:0]   bright;
    } t_cmd;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BR_START,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_STEP_START,
        ST_STEP_WAIT,
        ST_PUSH
    } t_front_state;

endpackage

/* design/lrhg_div.sv */
// ============================================================================
// lrhg_div : restoring divider, one quotient bit per cycle
// Unsigned dividend by nonzero divisor. done pulses for one cycle once
// quotient and remainder are final.
// ============================================================================
module lrhg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lrhg_pkg::t_div_req i_req,
    output lrhg_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [lrhg_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [lrhg_pkg::DIV_DVD_W-1:0] r_dvd;   // dividend shifts out, quotient shifts in
    logic [lrhg_pkg::DIV_DSR_W-1:0] r_dsr;
    logic [lrhg_pkg::DIV_DSR_W-1:0] r_rem;

    logic [lrhg_pkg::DIV_DSR_W:0]   w_trial;
    logic                           w_fit;

    // shift in next dividend bit and try the subtract
    assign w_trial = {r_rem, r_dvd[lrhg_pkg::DIV_DVD_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lrhg_pkg::DIV_CNT_W'(lrhg_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_dvd <= {r_dvd[lrhg_pkg::DIV_DVD_W-2:0], w_fit};
            r_rem <= w_fit ? lrhg_pkg::DIV_DSR_W'(w_trial - {1'b0, r_dsr})
                           : w_trial[lrhg_pkg::DIV_DSR_W-1:0];
        end else if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_dvd;
    assign o_rsp.remainder = r_rem;

endmodule

/* design/lrhg_front.sv */
// ============================================================================
// lrhg_front : request intake and setup sequencer
// Clamps count and ring size, works out brightness by a reciprocal multiply,
// then first index and hue step (zero for a single pixel) on the shared
// divider, and pushes one command word per request with a nonzero count.
// ============================================================================
module lrhg_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lrhg_pkg::CNT_W-1:0]        i_ring_size,
    input  logic [lrhg_pkg::CH_W-1:0]         i_max_bright,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [lrhg_pkg::CNT_W-1:0]        i_start_pixel,
    input  logic [lrhg_pkg::CNT_W-1:0]        i_pixel_count,
    input  logic [lrhg_pkg::HUE_W-1:0]        i_hue_start,
    input  logic [lrhg_pkg::HUE_W-1:0]        i_hue_end,
    input  logic [lrhg_pkg::PCT_W-1:0]        i_bright_pct,
    output lrhg_pkg::t_div_req                o_div_req,
    input  lrhg_pkg::t_div_rsp                i_div_rsp,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output lrhg_pkg::t_cmd                    o_q_cmd
);

    lrhg_pkg::t_front_state r_state, n_state;

    logic [lrhg_pkg::CNT_W-1:0]  r_sp;
    logic [lrhg_pkg::CNT_W-1:0]  r_cnt;
    logic [lrhg_pkg::CNT_W-1:0]  r_ring;
    logic [lrhg_pkg::HUE_W-1:0]  r_hs;
    logic [lrhg_pkg::HUE_W-1:0]  r_he;
    logic [lrhg_pkg::PROD_W-1:0] r_prod;
    logic [lrhg_pkg::CH_W-1:0]   r_bright;
    logic [lrhg_pkg::IDX_W-1:0]  r_first;
    logic [lrhg_pkg::STEP_W-1:0] r_step;

    logic                                          w_accept;
    logic [lrhg_pkg::CNT_W-1:0]                    w_cnt_clamp;
    logic [lrhg_pkg::CNT_W-1:0]                    w_ring_clamp;
    logic [lrhg_pkg::PROD_W-1:0]                   w_prod;
    logic [lrhg_pkg::PROD_W+lrhg_pkg::RECIP_W-1:0] w_scaled;
    logic [lrhg_pkg::BQ_W-1:0]                     w_bright_q;
    logic [lrhg_pkg::CNT_W-1:0]                    w_sp_abs;
    logic [lrhg_pkg::STEP_W-1:0]                   w_diff;
    logic [lrhg_pkg::STEP_W-1:0]                   w_diff_abs;
    logic [lrhg_pkg::STEP_W-1:0]                   w_quo;
    logic [lrhg_pkg::CNT_W-1:0]                    w_rem;

    assign w_accept = i_valid && o_ready;

    // clamp count and ring to the supported range
    always_comb begin
        w_cnt_clamp = i_pixel_count;
        if (i_pixel_count > lrhg_pkg::CNT_W'(lrhg_pkg::MAX_PIXELS))
            w_cnt_clamp = lrhg_pkg::CNT_W'(lrhg_pkg::MAX_PIXELS);
        w_ring_clamp = i_ring_size;
        if (i_ring_size == '0)
            w_ring_clamp = lrhg_pkg::CNT_W'(1);
        else if (i_ring_size > lrhg_pkg::CNT_W'(lrhg_pkg::MAX_PIXELS))
            w_ring_clamp = lrhg_pkg::CNT_W'(lrhg_pkg::MAX_PIXELS);
    end

    // brightness product at intake, divide by 100 as multiply and shift
    assign w_prod     = {{lrhg_pkg::PCT_W{1'b0}}, i_max_bright}
                      * {{lrhg_pkg::CH_W{1'b0}}, i_bright_pct};
    assign w_scaled   = {{lrhg_pkg::RECIP_W{1'b0}}, r_prod}
                      * {{lrhg_pkg::PROD_W{1'b0}}, lrhg_pkg::PCT_RECIP};
    assign w_bright_q = w_scaled[lrhg_pkg::RECIP_SH +: lrhg_pkg::BQ_W];

    // divider operands
    assign w_sp_abs   = r_sp[lrhg_pkg::CNT_W-1] ? (~r_sp + 1'b1) : r_sp;
    assign w_diff     = {1'b0, r_he} - {1'b0, r_hs};
    assign w_diff_abs = w_diff[lrhg_pkg::STEP_W-1] ? (~w_diff + 1'b1) : w_diff;
    assign w_quo      = i_div_rsp.quotient[lrhg_pkg::STEP_W-1:0];
    assign w_rem      = i_div_rsp.remainder;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrhg_pkg::ST_IDLE: begin
                if (w_accept && (i_pixel_count != '0)) n_state = lrhg_pkg::ST_BR_START;
            end
            lrhg_pkg::ST_BR_START:  n_state = lrhg_pkg::ST_MOD_START;
            lrhg_pkg::ST_MOD_START: n_state = lrhg_pkg::ST_MOD_WAIT;
            lrhg_pkg::ST_MOD_WAIT: begin
                if (i_div_rsp.done) n_state = lrhg_pkg::ST_STEP_START;
            end
            lrhg_pkg::ST_STEP_START: begin
                if (r_cnt == lrhg_pkg::CNT_W'(1)) n_state = lrhg_pkg::ST_PUSH;
                else                               n_state = lrhg_pkg::ST_STEP_WAIT;
            end
            lrhg_pkg::ST_STEP_WAIT: begin
                if (i_div_rsp.done) n_state = lrhg_pkg::ST_PUSH;
            end
            lrhg_pkg::ST_PUSH: begin
                if (!i_q_full) n_state = lrhg_pkg::ST_IDLE;
            end
            default: n_state = lrhg_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready            = 1'b0;
        o_q_push           = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = '0;
        o_div_req.divisor  = '0;
        case (r_state)
            lrhg_pkg::ST_IDLE:     o_ready = 1'b1;
            lrhg_pkg::ST_MOD_START: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = lrhg_pkg::DIV_DVD_W'(w_sp_abs);
                o_div_req.divisor  = r_ring;
            end
            lrhg_pkg::ST_STEP_START: begin
                o_div_req.start    = (r_cnt != lrhg_pkg::CNT_W'(1));
                o_div_req.dividend = lrhg_pkg::DIV_DVD_W'(w_diff_abs);
                o_div_req.divisor  = r_cnt - 1'b1;
            end
            lrhg_pkg::ST_PUSH:     o_q_push = !i_q_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lrhg_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // request fields and setup results
    always_ff @(posedge i_clk) begin
        case (r_state)
            lrhg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_sp   <= i_start_pixel;
                    r_cnt  <= w_cnt_clamp;
                    r_ring <= w_ring_clamp;
                    r_hs   <= i_hue_start;
                    r_he   <= i_hue_end;
                    r_prod <= w_prod;
                end
            end
            lrhg_pkg::ST_BR_START: begin
                // percent above 100 can push the result past 255, which saturates at full scale
                r_bright <= (w_bright_q > lrhg_pkg::BQ_W'(lrhg_pkg::CH_ON))
                            ? lrhg_pkg::CH_ON : w_bright_q[lrhg_pkg::CH_W-1:0];
            end
            lrhg_pkg::ST_MOD_WAIT: begin
                // negative start wraps back from the ring end
                if (i_div_rsp.done) begin
                    if (r_sp[lrhg_pkg::CNT_W-1] && (w_rem != '0))
                        r_first <= lrhg_pkg::IDX_W'(r_ring - w_rem);
                    else
                        r_first <= w_rem[lrhg_pkg::IDX_W-1:0];
                end
            end
            lrhg_pkg::ST_STEP_START: begin
                if (r_cnt == lrhg_pkg::CNT_W'(1)) r_step <= '0;
            end
            lrhg_pkg::ST_STEP_WAIT: begin
                // truncate toward zero: divide magnitude, restore sign
                if (i_div_rsp.done)
                    r_step <= w_diff[lrhg_pkg::STEP_W-1] ? (~w_quo + 1'b1) : w_quo;
            end
            default: ;
        endcase
    end

    assign o_q_cmd.first     = r_first;
    assign o_q_cmd.ring      = r_ring;
    assign o_q_cmd.count     = r_cnt;
    assign o_q_cmd.hue_start = r_hs;
    assign o_q_cmd.step      = r_step;
    assign o_q_cmd.bright    = r_bright;

endmodule

/* design/lrhg_queue.sv */
// ============================================================================
// lrhg_queue : short command queue between front and back
// Register-based FIFO, first-word fall-through.
// ============================================================================
module lrhg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lrhg_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lrhg_pkg::t_cmd o_cmd
);

    lrhg_pkg::t_cmd                r_mem [lrhg_pkg::QDEPTH];
    logic [lrhg_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [lrhg_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [lrhg_pkg::QPTR_W:0]     r_fill;

    assign o_full  = (r_fill == (lrhg_pkg::QPTR_W+1)'(lrhg_pkg::QDEPTH));
    assign o_empty = (r_fill == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

endmodule

/* design/lrhg_back.sv */
// ============================================================================
// lrhg_back : pixel generator and color conversion
// Walks a command, a pixel a cycle unless stalled: index wraps at ring size,
// hue steps by a fixed amount, full-saturation HSV to RGB, registered output.
// ============================================================================
module lrhg_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  lrhg_pkg::t_cmd              i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lrhg_pkg::IDX_W-1:0]  o_pixel_index,
    output lrhg_pkg::t_rgb              o_rgb,
    output logic [lrhg_pkg::CH_W-1:0]   o_brightness,
    output logic                        o_last
);

    // hue in 0..511 to color
    function automatic lrhg_pkg::t_rgb hue_rgb(input logic [lrhg_pkg::HUE_W-1:0] hue);
        logic [lrhg_pkg::HUE_W-1:0] hm;
        logic [lrhg_pkg::HUE_W-1:0] base;
        logic [2:0]                 sec;
        logic [5:0]                 k;
        logic [9:0]                 up17;
        logic [9:0]                 dn17;
        logic [lrhg_pkg::CH_W-1:0]  up;
        logic [lrhg_pkg::CH_W-1:0]  dn;
        lrhg_pkg::t_rgb             c;
        hm = (hue >= lrhg_pkg::HUE_FULL) ? (hue - lrhg_pkg::HUE_FULL) : hue;
        if (hm < lrhg_pkg::HUE_SECTOR) begin
            sec = lrhg_pkg::SEC_RY; base = '0;
        end else if (hm < 2 * lrhg_pkg::HUE_SECTOR) begin
            sec = lrhg_pkg::SEC_YG; base = lrhg_pkg::HUE_SECTOR;
        end else if (hm < 3 * lrhg_pkg::HUE_SECTOR) begin
            sec = lrhg_pkg::SEC_GC; base = lrhg_pkg::HUE_W'(2 * lrhg_pkg::HUE_SECTOR);
        end else if (hm < 4 * lrhg_pkg::HUE_SECTOR) begin
            sec = lrhg_pkg::SEC_CB; base = lrhg_pkg::HUE_W'(3 * lrhg_pkg::HUE_SECTOR);
        end else if (hm < 5 * lrhg_pkg::HUE_SECTOR) begin
            sec = lrhg_pkg::SEC_BM; base = lrhg_pkg::HUE_W'(4 * lrhg_pkg::HUE_SECTOR);
        end else begin
            sec = lrhg_pkg::SEC_MR; base = lrhg_pkg::HUE_W'(5 * lrhg_pkg::HUE_SECTOR);
        end
        k    = 6'(hm - base);
        // ramps are floor(17k/4) rising and floor(17(60-k)/4) falling
        up17 = {4'b0, k} * 10'd17;
        dn17 = (10'(lrhg_pkg::HUE_SECTOR) - {4'b0, k}) * 10'd17;
        up   = up17[9:2];
        dn   = dn17[9:2];
        case (sec)
            lrhg_pkg::SEC_RY: c = '{lrhg_pkg::CH_ON,  up,               lrhg_pkg::CH_OFF};
            lrhg_pkg::SEC_YG: c = '{dn,               lrhg_pkg::CH_ON,  lrhg_pkg::CH_OFF};
            lrhg_pkg::SEC_GC: c = '{lrhg_pkg::CH_OFF, lrhg_pkg::CH_ON,  up};
            lrhg_pkg::SEC_CB: c = '{lrhg_pkg::CH_OFF, dn,               lrhg_pkg::CH_ON};
            lrhg_pkg::SEC_BM: c = '{up,               lrhg_pkg::CH_OFF, lrhg_pkg::CH_ON};
            default:          c = '{lrhg_pkg::CH_ON,  lrhg_pkg::CH_OFF, dn};
        endcase
        return c;
    endfunction

    // generator state
    logic                        r_active;
    logic [lrhg_pkg::IDX_W-1:0]  r_idx;
    logic [lrhg_pkg::CNT_W-1:0]  r_ring;
    logic [lrhg_pkg::CNT_W-1:0]  r_left;
    logic [lrhg_pkg::STEP_W-1:0] r_hue;
    logic [lrhg_pkg::STEP_W-1:0] r_step;
    logic [lrhg_pkg::CH_W-1:0]   r_bright;

    // output register
    logic                        r_out_valid;
    logic [lrhg_pkg::IDX_W-1:0]  r_out_idx;
    lrhg_pkg::t_rgb              r_out_rgb;
    logic [lrhg_pkg::CH_W-1:0]   r_out_bright;
    logic                        r_out_last;

    logic                        w_load;
    logic                        w_last;
    logic                        w_wrap;

    assign o_q_pop = !r_active && !i_q_empty;
    assign w_load  = r_active && (!r_out_valid || i_ready);
    assign w_last  = (r_left == lrhg_pkg::CNT_W'(1));
    assign w_wrap  = (({1'b0, r_idx} + 1'b1) == r_ring);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop)
                r_active <= 1'b1;
            else if (w_load && w_last)
                r_active <= 1'b0;
            if (w_load)
                r_out_valid <= 1'b1;
            else if (i_ready)
                r_out_valid <= 1'b0;
        end
    end

    // pixel walk
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_idx    <= i_q_cmd.first;
            r_ring   <= i_q_cmd.ring;
            r_left   <= i_q_cmd.count;
            r_hue    <= {1'b0, i_q_cmd.hue_start};
            r_step   <= i_q_cmd.step;
            r_bright <= i_q_cmd.bright;
        end else if (w_load) begin
            r_idx  <= w_wrap ? '0 : r_idx + 1'b1;
            r_left <= r_left - 1'b1;
            r_hue  <= r_hue + r_step;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_idx    <= r_idx;
            r_out_rgb    <= hue_rgb(r_hue[lrhg_pkg::HUE_W-1:0]);
            r_out_bright <= r_bright;
            r_out_last   <= w_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_index = r_out_idx;
    assign o_rgb         = r_out_rgb;
    assign o_brightness  = r_out_bright;
    assign o_last        = r_out_last;

endmodule

/* design/led_ring_hue_gradient_core.sv */
// ============================================================================
// led_ring_hue_gradient_core : hue gradient painter for an LED ring
// Expands each gradient request into one pixel write per lit LED.
//
//  channel   dir  handshake                    word
//  s_axis    in   tvalid/tready                one gradient request
//  m_axis    out  tvalid/tready, tlast         one pixel write, tlast on final
//  cfg       in   i_cfg_we, no wait            ring_size, max_brightness
//
// Setup per request: accept, brightness by reciprocal multiply, then start
// index modulo ring and hue step on the shared bit-serial divider (the step
// division is skipped for a single pixel), and a push. The pixel walk pops
// a command and then emits one write per cycle while the output is not
// stalled. Reset is synchronous; it clears the sequencer, queue and output
// valid. A stalled output holds the walk; the two-deep queue lets setup run
// ahead.
// ============================================================================
module led_ring_hue_gradient_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // start_pixel[6:0], pixel_count[13:7],
                                          // hue_start[22:14], hue_end[31:23],
                                          // brightness_percent[38:32]
    // pixel stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // pixel_index[5:0], red[13:6],
                                          // green[21:14], blue[29:22],
                                          // brightness[37:30]
    output logic        o_m_axis_tlast
);

    logic [lrhg_pkg::CNT_W-1:0] r_ring_size;
    logic [lrhg_pkg::CH_W-1:0]  r_max_bright;

    lrhg_pkg::t_div_req         w_div_req;
    lrhg_pkg::t_div_rsp         w_div_rsp;
    lrhg_pkg::t_cmd             w_push_cmd;
    lrhg_pkg::t_cmd             w_head_cmd;
    logic                       w_push;
    logic                       w_pop;
    logic                       w_full;
    logic                       w_empty;
    logic [lrhg_pkg::IDX_W-1:0] w_pix_idx;
    lrhg_pkg::t_rgb             w_rgb;
    logic [lrhg_pkg::CH_W-1:0]  w_bright;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size  <= lrhg_pkg::RING_SIZE_RST;
            r_max_bright <= lrhg_pkg::MAX_BRIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lrhg_pkg::CFG_RING_SIZE:  r_ring_size  <= i_cfg_wdata[lrhg_pkg::CNT_W-1:0];
                lrhg_pkg::CFG_MAX_BRIGHT: r_max_bright <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    lrhg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ring_size   (r_ring_size),
        .i_max_bright  (r_max_bright),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_start_pixel (i_s_axis_tdata[6:0]),
        .i_pixel_count (i_s_axis_tdata[13:7]),
        .i_hue_start   (i_s_axis_tdata[22:14]),
        .i_hue_end     (i_s_axis_tdata[31:23]),
        .i_bright_pct  (i_s_axis_tdata[38:32]),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp),
        .i_q_full      (w_full),
        .o_q_push      (w_push),
        .o_q_cmd       (w_push_cmd)
    );

    lrhg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    lrhg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    lrhg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_empty),
        .i_q_cmd       (w_head_cmd),
        .o_q_pop       (w_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_pixel_index (w_pix_idx),
        .o_rgb         (w_rgb),
        .o_brightness  (w_bright),
        .o_last        (o_m_axis_tlast)
    );

    // pack the pixel word
    assign o_m_axis_tdata = {2'b00, w_bright, w_rgb.blue, w_rgb.green, w_rgb.red, w_pix_idx};

endmodule
